### hdl/fli_pkg.sv
// Package for the force layout node integrator: widths, register indexes,
// controller commands and the shared command/status types. No dependencies.
package fli_pkg;
    localparam int MAX_NODES   = 4096;
    localparam int COORD_WIDTH = 32;
    localparam int SAT_W       = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

    localparam logic [2:0] REG_VEL_DECAY   = 3'd0;
    localparam logic [2:0] REG_ALPHA_DECAY = 3'd1;
    localparam logic [2:0] REG_ALPHA_FLOOR = 3'd2;
    localparam logic [2:0] REG_TIME_STEP   = 3'd3;
    localparam logic [2:0] REG_MAX_DISP    = 3'd4;
    localparam logic [2:0] REG_COOL_DELAY  = 3'd5;
    localparam logic [2:0] REG_COOL_ARMED  = 3'd6;

    localparam logic [15:0] ALPHA_ONE = 16'd32768;
    localparam logic [47:0] SUM_MAX   = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic load;
        logic decay;
        logic sqrt_start;
        logic sqrt_step;
        logic clamp_check;
        logic div_start;
        logic div_step;
        logic div_sel_y;
        logic div_store;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic frozen;
        logic sqrt_done;
        logic need_clamp;
        logic div_done;
    } t_status;
endpackage

### hdl/fli_datapath.sv
// Datapath of the node integrator: decay, accumulation, iterative square root,
// iterative clamp divider, position update and tick state. Uses fli_pkg.
module fli_datapath
    import fli_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_status      o_status,
    input  logic         i_cfg_valid,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic [130:0] i_data,
    output logic [145:0] o_data
);
    logic [15:0] r_vdecay, r_adecay, r_afloor, r_tstep, r_cdelay;
    logic [30:0] r_maxd;
    logic        r_armed;
    logic [15:0] r_alpha;
    logic [31:0] r_ticks;
    logic        r_active;
    logic [47:0] r_sum;
    logic [15:0] r_tally;

    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic        r_drag, r_anyd, r_last;
    logic [63:0] r_rem, r_root, r_bit;
    logic [47:0] r_step;
    logic [62:0] r_num, r_quo;
    logic [63:0] r_drem;
    logic [6:0]  r_cnt;
    logic [5:0]  r_dcnt;
    logic        r_frozen;

    logic [15:0] alpha_eff;
    logic signed [48:0] dx, dy;
    logic [31:0] mx, my;
    logic [32:0] add_v;
    logic [48:0] sum_n;
    logic [64:0] sq_try;
    logic [64:0] d_try;
    logic [63:0] d_shift;
    logic [31:0] qm;
    logic signed [32:0] vsel;
    logic signed [31:0] vnew;
    logic signed [49:0] npx, npy;
    logic [31:0] cool_a;
    logic [15:0] alpha_n;
    logic [15:0] nval;
    logic        stop;

    assign alpha_eff = i_data[129] ? ALPHA_ONE : r_alpha;
    assign dx = ($signed({{16{r_vx[31]}}, r_vx}) * $signed({1'b0, r_vdecay})) >>> 16;
    assign dy = ($signed({{16{r_vy[31]}}, r_vy}) * $signed({1'b0, r_vdecay})) >>> 16;
    assign mx = r_vx[31] ? 32'(-r_vx) : 32'(r_vx);
    assign my = r_vy[31] ? 32'(-r_vy) : 32'(r_vy);
    assign add_v = {1'b0, mx} + {1'b0, my};
    assign sum_n = {1'b0, r_sum} + {16'd0, add_v};
    assign sq_try = {1'b0, r_rem} - ({1'b0, r_root} + {1'b0, r_bit});
    assign d_shift = {r_drem[62:0], r_num[62]};
    assign d_try = {1'b0, d_shift} - {17'd0, r_step};
    assign qm = r_quo[31:0];
    assign vsel = i_cmd.div_sel_y ? {r_vy[31], r_vy} : {r_vx[31], r_vx};
    assign vnew = vsel[32] ? 32'(-qm) : 32'(qm);
    assign npx = 50'(r_px) + 50'(($signed({{16{r_vx[31]}}, r_vx})
                 * $signed({1'b0, r_tstep})) >>> 8);
    assign npy = 50'(r_py) + 50'(($signed({{16{r_vy[31]}}, r_vy})
                 * $signed({1'b0, r_tstep})) >>> 8);
    assign cool_a = ({16'd0, r_alpha} * (32'd65536 - {16'd0, r_adecay})) >> 16;
    assign nval = (r_tally == 16'd0) ? 16'd1 : r_tally;

    always_comb begin
        alpha_n = r_alpha;
        if (!r_anyd && r_armed && ((r_ticks + 32'd1) >= {16'd0, r_cdelay})) begin
            alpha_n = cool_a[15:0];
        end
        stop = !r_anyd && ((56'(r_sum) * 56'd100) < (56'(nval) << 16))
               && ((24'(alpha_n) * 24'd100) < 24'(ALPHA_ONE));
    end

    function automatic logic signed [31:0] sat(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = (50'sd1 <<< (SAT_W - 1)) - 50'sd1;
        lo = -hi - 50'sd1;
        if (v > hi) begin
            sat = 32'(hi);
        end else if (v < lo) begin
            sat = 32'(lo);
        end else begin
            sat = 32'(v);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vdecay <= 16'd39322; r_adecay <= 16'd1494; r_afloor <= 16'd33;
            r_tstep <= 16'd256; r_maxd <= 31'd6553600; r_cdelay <= 16'd0;
            r_armed <= 1'b1; r_alpha <= ALPHA_ONE; r_ticks <= 32'd0;
            r_active <= 1'b1; r_sum <= 48'd0; r_tally <= 16'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_VEL_DECAY:   r_vdecay <= i_cfg_data[15:0];
                    REG_ALPHA_DECAY: r_adecay <= i_cfg_data[15:0];
                    REG_ALPHA_FLOOR: r_afloor <= i_cfg_data[15:0];
                    REG_TIME_STEP:   r_tstep  <= i_cfg_data[15:0];
                    REG_MAX_DISP:    r_maxd   <= i_cfg_data[30:0];
                    REG_COOL_DELAY:  r_cdelay <= i_cfg_data[15:0];
                    REG_COOL_ARMED:  r_armed  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_alpha <= alpha_eff;
                if (alpha_eff <= r_afloor) begin
                    r_active <= 1'b0;
                end else if (i_data[129]) begin
                    r_active <= 1'b1;
                end
            end
            if (i_cmd.sqrt_start) begin
                if (sum_n[48]) begin
                    r_sum <= SUM_MAX;
                end else begin
                    r_sum <= sum_n[47:0];
                end
                if (r_tally < 16'(MAX_NODES)) r_tally <= r_tally + 16'd1;
            end
            if (i_cmd.finish && r_last) begin
                r_sum <= 48'd0;
                r_tally <= 16'd0;
                if (!r_frozen) begin
                    r_ticks <= r_ticks + 32'd1;
                    r_alpha <= alpha_n;
                    if (stop) r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_data[31:0]; r_py <= i_data[63:32];
            r_vx <= i_data[95:64]; r_vy <= i_data[127:96];
            r_drag <= i_data[128]; r_anyd <= i_data[129]; r_last <= i_data[130];
            r_frozen <= alpha_eff <= r_afloor;
        end
        if (i_cmd.decay) begin
            r_vx <= 32'(dx);
            r_vy <= 32'(dy);
        end
        if (i_cmd.sqrt_start) begin
            r_rem  <= 64'(mx) * 64'(mx) + 64'(my) * 64'(my);
            r_root <= 64'd0;
            r_bit  <= 64'd1 << 62;
            r_cnt  <= 7'd0;
        end
        if (i_cmd.sqrt_step) begin
            if (!sq_try[64]) begin
                r_rem  <= sq_try[63:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 7'd1;
        end
        if (i_cmd.clamp_check) begin
            r_step <= 48'((r_root[47:0] * 64'(r_tstep)) >> 8);
        end
        if (i_cmd.div_start) begin
            r_num  <= 63'((i_cmd.div_store ? 63'(my) : 63'(mx)) * 63'(r_maxd));
            r_drem <= 64'd0;
            r_quo  <= 63'd0;
            r_dcnt <= 6'd0;
        end
        if (i_cmd.div_step) begin
            r_num <= {r_num[61:0], 1'b0};
            if (!d_try[64]) begin
                r_drem <= d_try[63:0];
                r_quo  <= {r_quo[61:0], 1'b1};
            end else begin
                r_drem <= d_shift;
                r_quo  <= {r_quo[61:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 6'd1;
        end
        if (i_cmd.div_store) begin
            if (i_cmd.div_sel_y) begin
                r_vy <= vnew;
            end else begin
                r_vx <= vnew;
            end
        end
        if (i_cmd.finish && !r_frozen && !r_drag) begin
            r_px <= sat(npx);
            r_py <= sat(npy);
        end
    end

    assign o_status.frozen     = r_frozen;
    assign o_status.sqrt_done  = (r_cnt == 7'd31);
    assign o_status.need_clamp = (r_step > {17'd0, r_maxd}) && (r_root != 64'd0) && !r_drag;
    assign o_status.div_done   = (r_dcnt == 6'd62);
    assign o_data = {r_last, r_active, r_alpha, r_vy, r_vx, r_py, r_px};
endmodule

### hdl/fli_controller.sv
// Controller state machine of the node integrator: sequences load, decay,
// square root, clamp division and write-back. Uses fli_pkg.
module fli_controller
    import fli_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0, S_DECAY = 4'd1, S_SQS = 4'd2,
        S_SQ = 4'd3, S_CHK = 4'd4, S_CMP = 4'd5, S_DXS = 4'd6, S_DX = 4'd7,
        S_DYS = 4'd8, S_DY = 4'd9, S_FIN = 4'd10, S_DYW = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       free_out;

    assign free_out = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && free_out;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && free_out) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECAY;
                end
            end
            S_DECAY: begin
                if (i_status.frozen) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.decay = 1'b1;
                    n_state = S_SQS;
                end
            end
            S_SQS: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_done) n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.clamp_check = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = i_status.need_clamp ? S_DXS : S_FIN;
            end
            S_DXS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DX;
            end
            S_DX: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_DYS;
            end
            S_DYS: begin
                o_cmd.div_store = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_y = 1'b0;
                n_state = S_DY;
            end
            S_DY: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_sel_y = 1'b1;
                if (i_status.div_done) n_state = S_DYW;
            end
            S_DYW: begin
                o_cmd.div_store = 1'b1;
                o_cmd.div_sel_y = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (free_out) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_FIN && o_cmd.finish == 1'b0) o_cmd.div_sel_y = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

### hdl/force_layout_node_integrator_core.sv
// Top level of the force layout node integrator: controller plus datapath.
// Depends on fli_pkg, fli_controller and fli_datapath.
//
// One request on the slave channel is one node of a layout tick; one request
// on the master channel returns that node updated. s_axis tdata carries
// pos_x, pos_y, vel_x, vel_y; tuser carries is_dragged and tick_has_drag;
// tlast marks the last node of a tick. m_axis tdata carries new_pos_x,
// new_pos_y, new_vel_x, new_vel_y, alpha_now, sim_active; tlast is tick_done.
// A node passes through load, decay, a 32-step square root and a clamp check;
// when its speed must be clamped a 63-step divide for each velocity component
// follows, and a node of a frozen tick skips straight to write-back.
// One node is handled at a time; the next is taken once the previous result
// has been taken or is taken in the same cycle. When the receiver stalls the
// result holds and the block waits. Reset returns alpha to one and restarts
// the simulation. The user must write registers on the cfg channel only while
// the block is idle; the block itself does not enforce it.
module force_layout_node_integrator_core
    import fli_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // pos_x, pos_y, vel_x, vel_y
    input  logic [1:0]   s_axis_tuser,   // is_dragged, tick_has_drag
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // new_pos_x, new_pos_y, new_vel_x,
                                         // new_vel_y, alpha_now, sim_active
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    t_cmd         cmd;
    t_status      status;
    logic [145:0] dp_out;
    logic [130:0] dp_in;

    assign o_cfg_ready = 1'b1;

    fli_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(status), .o_cmd(cmd)
    );

    fli_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_data(dp_in), .o_data(dp_out)
    );

    assign dp_in = {s_axis_tlast, s_axis_tuser, s_axis_tdata};
    assign m_axis_tdata = {7'd0, dp_out[144:0]};
    assign m_axis_tlast = dp_out[145];
endmodule

### hdl/fli_checker.sv
// Port checker for the node integrator core, bound to the top level.
// Depends on force_layout_node_integrator_core ports only.
module fli_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [151:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[143:128] <= 16'd32768)
        else $error("alpha out of range");
endmodule

bind force_layout_node_integrator_core fli_checker u_fli_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

### tb/tb_force_layout_node_integrator_core.sv
// Self-checking testbench for force_layout_node_integrator_core.
// Drives node requests and register writes, predicts each updated node in SystemVerilog
// and compares it with the master channel. Depends on fli_pkg and the core.
`timescale 1ns / 1ps

module tb_force_layout_node_integrator_core;
    import fli_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE = 200;

    typedef struct {
        logic signed [31:0] px, py, vx, vy;
        bit drag, any_drag, last;
    } node_t;

    typedef struct {
        logic signed [31:0] px, py, vx, vy;
        logic [15:0] alpha;
        bit active, done;
    } update_t;

    typedef struct {
        bit is_cfg;
        logic [2:0] idx;
        logic [31:0] cdata;
        node_t n;
        bit chk;
        update_t x;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [151:0] m_axis_tdata;
    logic m_axis_tlast;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    force_layout_node_integrator_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor copy of registers and state.
    int unsigned vel_decay, alpha_decay, alpha_floor, time_step, max_disp, cool_delay;
    bit cool_armed;
    int unsigned alpha;
    bit [31:0] tick_count;
    bit active;
    longint unsigned speed_sum;
    int unsigned node_tally;

    update_t pending_updates[$];
    row_t stim_table[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic void reset_model();
        vel_decay = 39322; alpha_decay = 1494; alpha_floor = 33; time_step = 256;
        max_disp = 6553600; cool_delay = 0; cool_armed = 1;
        alpha = ALPHA_ONE; tick_count = 0; active = 1; speed_sum = 0; node_tally = 0;
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            REG_VEL_DECAY:   vel_decay = d[15:0];
            REG_ALPHA_DECAY: alpha_decay = d[15:0];
            REG_ALPHA_FLOOR: alpha_floor = d[15:0];
            REG_TIME_STEP:   time_step = d[15:0];
            REG_MAX_DISP:    max_disp = d[30:0];
            REG_COOL_DELAY:  cool_delay = d[15:0];
            REG_COOL_ARMED:  cool_armed = d[0];
            default: ;
        endcase
    endfunction

    function automatic update_t advance_node(node_t n);
        longint px, py, vx, vy;
        longint unsigned ax, ay, add, spd, stp, cnt;
        update_t r;
        px = n.px; py = n.py; vx = n.vx; vy = n.vy;
        if (n.any_drag) begin
            alpha = ALPHA_ONE;
            active = 1;
        end
        if (alpha <= alpha_floor) begin
            active = 0;
            if (n.last) begin
                speed_sum = 0;
                node_tally = 0;
            end
        end else begin
            vx = (vx * longint'(vel_decay)) >>> 16;
            vy = (vy * longint'(vel_decay)) >>> 16;
            ax = (vx < 0) ? -vx : vx;
            ay = (vy < 0) ? -vy : vy;
            add = ax + ay;
            speed_sum = (longint'(SUM_MAX) - speed_sum < add) ? longint'(SUM_MAX)
                                                              : speed_sum + add;
            if (node_tally < MAX_NODES) node_tally++;
            if (!n.drag) begin
                spd = root64(ax * ax + ay * ay);
                stp = (spd * time_step) >> 8;
                if (stp > max_disp && spd > 0) begin
                    vx = (vx < 0) ? -longint'(ax * max_disp / stp) : longint'(ax * max_disp / stp);
                    vy = (vy < 0) ? -longint'(ay * max_disp / stp) : longint'(ay * max_disp / stp);
                end
                px = sat32(px + ((vx * longint'(time_step)) >>> 8));
                py = sat32(py + ((vy * longint'(time_step)) >>> 8));
            end
            if (n.last) begin
                cnt = (node_tally != 0) ? node_tally : 1;
                tick_count++;
                if (!n.any_drag && cool_armed && tick_count >= cool_delay)
                    alpha = (longint'(alpha) * (65536 - alpha_decay)) >> 16;
                if (!n.any_drag && speed_sum * 100 < cnt * 65536 && alpha * 100 < ALPHA_ONE)
                    active = 0;
                speed_sum = 0;
                node_tally = 0;
            end
        end
        r.px = px[31:0]; r.py = py[31:0]; r.vx = vx[31:0]; r.vy = vy[31:0];
        r.alpha = alpha[15:0]; r.active = active; r.done = n.last;
        return r;
    endfunction

    function automatic bit same_update(update_t e, update_t g, string tag);
        bit [31:0] ef[7], gf[7];
        string nm[7];
        bit ok = 1;
        nm = '{"new_pos_x", "new_pos_y", "new_vel_x", "new_vel_y", "alpha_now",
               "sim_active", "tick_done"};
        ef = '{e.px, e.py, e.vx, e.vy, e.alpha, e.active, e.done};
        gf = '{g.px, g.py, g.vx, g.vy, g.alpha, g.active, g.done};
        for (int i = 0; i < 7; i++) begin
            if (ef[i] !== gf[i]) begin
                $display("%0t %s %s: expected %h, actual %h", $time, tag, nm[i], ef[i], gf[i]);
                ok = 0;
            end
        end
        return ok;
    endfunction

    // Receiver: random stall and result check against the oldest prediction.
    always @(posedge i_clk) begin
        update_t got, want;
        cycles <= cycles + 1;
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.px = m_axis_tdata[31:0];
            got.py = m_axis_tdata[63:32];
            got.vx = m_axis_tdata[95:64];
            got.vy = m_axis_tdata[127:96];
            got.alpha = m_axis_tdata[143:128];
            got.active = m_axis_tdata[144];
            got.done = m_axis_tlast;
            if (pending_updates.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = pending_updates.pop_front();
                if (!same_update(want, got, "result")) errors++;
                if (m_axis_tdata[151:145] !== '0) begin
                    $display("%0t padding: expected 0, actual %h", $time, m_axis_tdata[151:145]);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_force_layout_node_integrator_core: errors");
            $finish;
        end
    end

    task automatic send_node(node_t n, bit chk, update_t x);
        update_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {n.vy, n.vx, n.py, n.px};
        s_axis_tuser <= {n.any_drag, n.drag};
        s_axis_tlast <= n.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        p = advance_node(n);
        if (chk && !same_update(x, p, "directed")) errors++;
        pending_updates.push_back(p);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        apply_cfg(idx, d);
        @(posedge i_clk);
    endtask

    function automatic int unsigned pick(int unsigned lo, int unsigned hi);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic random_config();
        write_reg(REG_VEL_DECAY, pick(0, 65535));
        write_reg(REG_ALPHA_DECAY, pick(0, 65535));
        write_reg(REG_ALPHA_FLOOR, ($urandom_range(7) == 0) ? pick(0, 32768)
                                                            : $urandom_range(400));
        write_reg(REG_TIME_STEP, pick(1, 65535));
        write_reg(REG_MAX_DISP, pick(0, 32'h7FFF_FFFF));
        write_reg(REG_COOL_DELAY, ($urandom_range(3) == 0) ? pick(0, 65535)
                                                          : $urandom_range(20));
        write_reg(REG_COOL_ARMED, $urandom_range(1));
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $signed($urandom_range(4000)) - 2000;
            1: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_tick(int len, bit noise);
        node_t n;
        update_t none;
        int held = $urandom_range(len - 1);
        bit any = ($urandom_range(4) == 0);
        int vm = $urandom_range(2);
        int pm = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
            n.px = rand_coord(pm); n.py = rand_coord(pm);
            n.vx = rand_coord(vm); n.vy = rand_coord(vm);
            n.any_drag = any;
            n.drag = any && (i == held);
            n.last = (i == len - 1);
            if (noise) begin
                n.drag = $urandom_range(1);
                n.any_drag = $urandom_range(1);
                n.last = $urandom_range(1);
            end
            send_node(n, 0, none);
        end
    endtask

    task automatic add_node(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                            logic [31:0] vy, bit drag, bit any, bit last);
        row_t r;
        r.is_cfg = 0;
        r.n = '{px, py, vx, vy, drag, any, last};
        r.chk = 0;
        stim_table.push_back(r);
    endtask

    task automatic add_checked(node_t n, update_t x);
        row_t r;
        r.is_cfg = 0; r.n = n; r.chk = 1; r.x = x;
        stim_table.push_back(r);
    endtask

    task automatic add_cfg(logic [2:0] idx, logic [31:0] d);
        row_t r;
        r.is_cfg = 1; r.idx = idx; r.cdata = d; r.chk = 0;
        stim_table.push_back(r);
    endtask

    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] PMIN = 32'h8000_0000;

    initial begin
        bit in_cfg;
        int sent;
        int len;
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_checked('{0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, ALPHA_ONE, 1, 0});
        add_node(PMAX, PMAX, PMAX, PMAX, 0, 0, 0);
        add_node(PMIN, PMIN, PMIN, PMIN, 0, 0, 0);
        add_node(1000, -1000, 5 << 16, -3 << 16, 1, 1, 0);
        add_node(7, 9, 300, -200, 0, 1, 1);
        add_node(-5, 5, 40, 40, 0, 0, 1);
        add_cfg(REG_TIME_STEP, 0);
        add_node(123, 456, PMAX, PMIN, 0, 0, 0);
        add_cfg(REG_TIME_STEP, 65535);
        add_cfg(REG_MAX_DISP, 0);
        add_node(0, 0, 70000, -90000, 0, 0, 0);
        add_cfg(REG_MAX_DISP, 32'h7FFF_FFFF);
        add_cfg(REG_VEL_DECAY, 65535);
        add_node(PMAX, PMIN, PMAX, PMIN, 0, 0, 0);
        add_cfg(REG_ALPHA_DECAY, 65535);
        add_cfg(REG_COOL_DELAY, 0);
        add_node(1, 2, 3, 4, 0, 0, 1);
        add_node(1, 2, 3, 4, 0, 0, 1);
        add_cfg(REG_ALPHA_FLOOR, 32768);
        add_checked('{123, 456, 789, -10, 0, 0, 0}, '{123, 456, 789, -10, 0, 0, 0});
        add_checked('{-1, PMAX, PMIN, 1, 0, 0, 1}, '{-1, PMAX, PMIN, 1, 0, 0, 1});
        add_cfg(3'd7, 32'hFFFF_FFFF);
        add_cfg(REG_ALPHA_FLOOR, 0);
        add_cfg(REG_COOL_ARMED, 0);
        add_node(10, 10, 1 << 20, 1 << 20, 1, 1, 1);
        add_node(10, 10, 1 << 20, 1 << 20, 0, 0, 1);

        in_cfg = 0;
        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg) begin
                if (!in_cfg) wait_idle();
                write_reg(stim_table[i].idx, stim_table[i].cdata);
            end else begin
                send_node(stim_table[i].n, stim_table[i].chk, stim_table[i].x);
            end
            in_cfg = stim_table[i].is_cfg;
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 47 : 0;
            recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 15 : 0;
            for (int part = 0; part < 2; part++) begin
                sent = 0;
                wait_idle();
                random_config();
                while (sent < 170) begin
                    len = $urandom_range(1, 8);
                    random_tick(len, $urandom_range(9) == 0);
                    sent += len;
                    if (ph == 1 && part == 0 && sent > 80 && sent <= 80 + len)
                        wait_idle();
                end
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("tb_force_layout_node_integrator_core: clean");
        end else begin
            $display("tb_force_layout_node_integrator_core: errors");
        end
        $finish;
    end
endmodule

### files.f
hdl/fli_pkg.sv
hdl/fli_datapath.sv
hdl/fli_controller.sv
hdl/force_layout_node_integrator_core.sv
hdl/fli_checker.sv
tb/tb_force_layout_node_integrator_core.sv
